>>> sv/plr_pkg.sv
package plr_pkg;

  // field widths of the request and result channels
  localparam int unsigned SET_W  = 10;
  localparam int unsigned WAY_W  = 4;
  localparam int unsigned DRAW_W = 5;
  localparam int unsigned NOW_W  = 32;
  localparam int unsigned CNT_W  = 15;

  // promote limit after reset
  localparam logic [CNT_W-1:0] LIMIT_RESET = 15'd8192;

  // request commands
  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

endpackage

>>> sv/plr_row_mem.sv
module plr_row_mem #(
  parameter int unsigned WIDTH = 528,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] ram_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ram_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/priority_lru_replacement_unit.sv
// Priority LRU replacement unit. Each set row (a last-use stamp and a
// high-priority bit for every way) sits in one single-port-per-direction
// row memory that is read once per request and written back at most once.
// A victim query, and a promoting hit with the promote quota full, search
// the row for the LRU way: the search walks the row one way per cycle
// through a single stamp comparator. A query answers on out_victim_way;
// updates produce no result. After reset the unit runs a clearing pass
// over every row of the row memory and stalls requests until it is done;
// cfg writes are taken at any time but must only be issued while no
// request is in flight.
module priority_lru_replacement_unit #(
  parameter int unsigned SETS      = 1024,
  parameter int unsigned WAYS      = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [plr_pkg::CNT_W-1:0]      cfg_wr_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [plr_pkg::SET_W-1:0]      in_set_index,
  input  logic [plr_pkg::WAY_W-1:0]      in_way_index,
  input  logic                           in_was_hit,
  input  logic                           in_is_write,
  input  logic [plr_pkg::DRAW_W-1:0]     in_random_draw,
  input  logic [plr_pkg::NOW_W-1:0]      in_now_time,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [plr_pkg::WAY_W-1:0]      out_victim_way
);

  localparam int unsigned SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_AW = $clog2(WAYS);
  localparam int unsigned ROW_W  = WAYS * (TIME_BITS + 1);

  typedef struct packed {
    logic [WAYS-1:0]                pri;
    logic [WAYS-1:0][TIME_BITS-1:0] stamp;
  } row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  state_t                      state_r;
  logic [SET_AW-1:0]           clr_r;
  logic [plr_pkg::CNT_W-1:0]   limit_r;
  logic [plr_pkg::CNT_W-1:0]   cnt_r;

  logic                        req_cmd_r;
  logic [SET_AW-1:0]           req_set_r;
  logic [WAY_AW-1:0]           req_way_r;
  logic                        req_hit_r;
  logic                        req_write_r;
  logic                        req_promote_r;
  logic [TIME_BITS-1:0]        req_now_r;

  logic                        want_r;
  logic                        found_r;
  logic [TIME_BITS-1:0]        best_r;
  logic [WAY_AW-1:0]           pick_r;
  logic [WAY_AW-1:0]           scan_r;

  logic                        out_valid_r;
  logic [plr_pkg::WAY_W-1:0]   out_way_r;

  logic                        in_acc;
  logic                        set_ok;
  logic                        way_ok;
  logic                        is_query;
  logic                        promote_in;
  logic                        quota_full;
  logic                        mem_we;
  logic [SET_AW-1:0]           mem_waddr;
  logic [ROW_W-1:0]            mem_rdata;
  row_t                        rd_row;
  row_t                        wr_row;
  logic                        cnt_inc;
  logic                        scan_take;

  // request decode
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign set_ok     = (32'(in_set_index) < SETS);
  assign way_ok     = (32'(in_way_index) < WAYS);
  assign is_query   = (in_command == plr_pkg::CMD_QUERY);
  assign promote_in = (in_random_draw == '0);
  assign quota_full = (cnt_r >= limit_r);

  // row memory
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_r : req_set_r;
  assign rd_row    = row_t'(mem_rdata);

  plr_row_mem #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_AW)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data ((state_r == ST_CLEAR) ? {ROW_W{1'b0}} : ROW_W'(wr_row)),
    .rd_en   (in_acc && set_ok),
    .rd_addr (SET_AW'(in_set_index)),
    .rd_data (mem_rdata)
  );

  // one way per cycle of the lru search
  assign scan_take = (rd_row.pri[scan_r] == want_r) &&
                     (!found_r || (rd_row.stamp[scan_r] < best_r));

  // row write-back for an update
  always_comb begin
    wr_row  = rd_row;
    cnt_inc = 1'b0;
    if (req_hit_r) begin
      if (req_promote_r && !quota_full) begin
        wr_row.pri[req_way_r] = 1'b1;
        cnt_inc               = 1'b1;
      end else if (req_promote_r) begin
        wr_row.pri[pick_r]    = 1'b0;
        wr_row.pri[req_way_r] = 1'b1;
      end else begin
        wr_row.pri[req_way_r] = 1'b0;
      end
      if (!req_write_r) begin
        wr_row.stamp[req_way_r] = req_now_r;
      end
    end else begin
      if (req_promote_r) begin
        wr_row.pri[req_way_r]   = 1'b1;
        wr_row.stamp[req_way_r] = req_now_r;
        cnt_inc                 = !quota_full;
      end else begin
        wr_row.pri[req_way_r] = 1'b0;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= plr_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // control state machine and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: raised from the result state, dropped once taken
      if ((state_r == ST_RESULT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_AW'(SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (is_query) begin
              state_r <= set_ok ? ST_SCAN : ST_RESULT;
            end else if (set_ok && way_ok) begin
              state_r <= (in_was_hit && promote_in && quota_full) ? ST_SCAN : ST_WRITE;
            end
          end
        end
        ST_SCAN: begin
          if (scan_r == WAY_AW'(WAYS - 1)) begin
            state_r <= (req_cmd_r == plr_pkg::CMD_QUERY) ? ST_RESULT : ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (cnt_inc) begin
            cnt_r <= cnt_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
        ST_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // request fields and search registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_cmd_r     <= in_command;
      req_set_r     <= SET_AW'(in_set_index);
      req_way_r     <= WAY_AW'(in_way_index);
      req_hit_r     <= in_was_hit;
      req_write_r   <= in_is_write;
      req_promote_r <= promote_in;
      req_now_r     <= TIME_BITS'(in_now_time);
      want_r        <= is_query ? quota_full : 1'b1;
      found_r       <= 1'b0;
      best_r        <= '0;
      pick_r        <= '0;
      scan_r        <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_r + 1'b1;
      if (scan_take) begin
        found_r <= 1'b1;
        best_r  <= rd_row.stamp[scan_r];
        pick_r  <= scan_r;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && (!out_valid_r || !out_stall)) begin
      out_way_r <= plr_pkg::WAY_W'(pick_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;

  // promote count only grows
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("promote count decreased");

  // promote count only moves on a row write-back
  a_cnt_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> ($past(state_r) == ST_WRITE))
    else $error("promote count changed outside write-back");

  // a new result only comes from the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid_r && !$past(out_valid_r) |-> ($past(state_r) == ST_RESULT))
    else $error("result raised outside result state");

  // an update only searches the row for a promoting hit
  a_scan_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) && ($past(state_r) == ST_SCAN) |-> (req_hit_r && req_promote_r))
    else $error("update searched without promoting hit");

endmodule
